/* hw/rtl/tdr_pkg.sv */
// Package for the TFTP download receiver: request, result, state and register types,
// protocol constants and codes. Depends on nothing.

package tdr_pkg;

  // Payload size of a full data block; a shorter block ends the transfer.
  localparam logic [15:0] BLOCK_SIZE = 16'd512;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [1:0] SEND_NONE   = 2'd0;
  localparam logic [1:0] SEND_ACK    = 2'd1;
  localparam logic [1:0] SEND_ERROR  = 2'd2;
  localparam logic [1:0] SEND_RESEND = 2'd3;

  localparam logic [1:0] ST_RUN      = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_FAILED   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] REG_LOCAL_PORT  = 2'd0;
  localparam logic [1:0] REG_BUFFER_SIZE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd3;

  localparam logic [15:0] ETHERTYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  UDP_PROTOCOL        = 8'd17;
  localparam logic [15:0] SERVER_PORT_DEFAULT = 16'd69;
  localparam logic [15:0] OP_DATA             = 16'd3;
  localparam logic [15:0] OP_ERROR            = 16'd5;
  // UDP header (8) plus TFTP data header (4).
  localparam logic [15:0] DATA_HDR_LEN   = 16'd12;
  localparam logic [16:0] ELAPSED_MAX    = 17'h1FFFF;

  localparam logic [15:0] LOCAL_PORT_RST  = 16'd40000;
  localparam logic [31:0] BUFFER_SIZE_RST = 32'd0;
  localparam logic [15:0] TIMEOUT_RST     = 16'd2000;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd5;

  typedef struct packed {
    logic [15:0] local_port;
    logic [31:0] buffer_size;
    logic [15:0] timeout_ticks;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_src_port;
    logic [15:0] udp_dst_port;
    logic [15:0] udp_length;
    logic [15:0] tftp_opcode;
    logic [15:0] block_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] ack_block;
    logic [15:0] server_port;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic [1:0]  status;
    logic [32:0] byte_total;
  } res_t;

  typedef struct packed {
    logic        active;
    logic [15:0] expected_block;
    logic [32:0] received_total;
    logic [4:0]  retry_count;
    logic [16:0] elapsed_ticks;
    logic [15:0] reply_port;
  } st_t;

endpackage

/* hw/rtl/tdr_req_if.sv */
// Request channel of the TFTP download receiver: valid/ready handshake and the
// parsed frame header fields. Depends on nothing.

interface tdr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [15:0] udp_src_port;
  logic [15:0] udp_dst_port;
  logic [15:0] udp_length;
  logic [15:0] tftp_opcode;
  logic [15:0] block_number;

  modport source (
    output valid, req_type, ether_type, ip_protocol, udp_src_port, udp_dst_port,
           udp_length, tftp_opcode, block_number,
    input  ready
  );
  modport sink (
    input  valid, req_type, ether_type, ip_protocol, udp_src_port, udp_dst_port,
           udp_length, tftp_opcode, block_number,
    output ready
  );
endinterface

/* hw/rtl/tdr_res_if.sv */
// Result channel of the TFTP download receiver: valid/ready handshake and the
// reply decision fields. Depends on nothing.

interface tdr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  send_kind;
  logic [15:0] ack_block;
  logic [15:0] server_port;
  logic [31:0] write_offset;
  logic [15:0] write_length;
  logic [1:0]  status;
  logic [32:0] byte_total;

  modport source (
    output valid, send_kind, ack_block, server_port, write_offset, write_length,
           status, byte_total,
    input  ready
  );
  modport sink (
    input  valid, send_kind, ack_block, server_port, write_offset, write_length,
           status, byte_total,
    output ready
  );
endinterface

/* hw/rtl/tdr_regs.sv */
// APB register file of the TFTP download receiver: four configuration registers.
// Depends on tdr_pkg.

module tdr_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output tdr_pkg::cfg_t cfg
);
  import tdr_pkg::*;

  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_port    <= LOCAL_PORT_RST;
      cfg.buffer_size   <= BUFFER_SIZE_RST;
      cfg.timeout_ticks <= TIMEOUT_RST;
      cfg.max_retries   <= MAX_RETRIES_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_LOCAL_PORT:  cfg.local_port    <= pwdata[15:0];
        REG_BUFFER_SIZE: cfg.buffer_size   <= pwdata;
        REG_TIMEOUT:     cfg.timeout_ticks <= pwdata[15:0];
        REG_MAX_RETRIES: cfg.max_retries   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOCAL_PORT:  prdata = {16'd0, cfg.local_port};
      REG_BUFFER_SIZE: prdata = cfg.buffer_size;
      REG_TIMEOUT:     prdata = {16'd0, cfg.timeout_ticks};
      REG_MAX_RETRIES: prdata = {28'd0, cfg.max_retries};
      default:         prdata = 32'd0;
    endcase
  end
endmodule

/* hw/rtl/tdr_step.sv */
// Transfer decision logic of the TFTP download receiver: from one request and the
// current transfer state, the next state and the result. Depends on tdr_pkg.

module tdr_step (
  input  tdr_pkg::cfg_t cfg,
  input  tdr_pkg::st_t  st,
  input  tdr_pkg::req_t rq,
  output tdr_pkg::st_t  st_next,
  output tdr_pkg::res_t rs
);
  import tdr_pkg::*;

  logic [16:0] elapsed;
  logic [4:0]  retries;
  logic [15:0] dlen;
  logic [32:0] room;
  logic [32:0] bufsz;
  logic        frame_ok;
  logic [1:0]  send;
  logic [15:0] ackb;
  logic [31:0] woff;
  logic [15:0] wlen;
  logic [1:0]  status;

  always_comb begin
    st_next  = st;
    send     = SEND_NONE;
    ackb     = 16'd0;
    woff     = 32'd0;
    wlen     = 16'd0;
    status   = ST_RUN;
    bufsz    = {1'b0, cfg.buffer_size};
    elapsed  = (st.elapsed_ticks < ELAPSED_MAX) ? st.elapsed_ticks + 17'd1 : st.elapsed_ticks;
    retries  = st.retry_count + 5'd1;
    dlen     = rq.udp_length - DATA_HDR_LEN;
    room     = bufsz - st.received_total;
    frame_ok = (rq.ether_type == ETHERTYPE_IPV4) && (rq.ip_protocol == UDP_PROTOCOL) &&
               (rq.udp_dst_port == cfg.local_port) && (rq.udp_length >= DATA_HDR_LEN);

    case (rq.req_type)
      REQ_START: begin
        st_next.active         = 1'b1;
        st_next.expected_block = 16'd1;
        st_next.received_total = 33'd0;
        st_next.retry_count    = 5'd0;
        st_next.elapsed_ticks  = 17'd0;
        st_next.reply_port     = SERVER_PORT_DEFAULT;
      end
      REQ_TICK: begin
        if (st.active) begin
          st_next.elapsed_ticks = elapsed;
          if (elapsed > {1'b0, cfg.timeout_ticks}) begin
            st_next.retry_count = retries;
            if (retries > {1'b0, cfg.max_retries}) begin
              status         = ST_FAILED;
              st_next.active = 1'b0;
            end else begin
              send                  = SEND_RESEND;
              st_next.elapsed_ticks = 17'd0;
            end
          end
        end
      end
      REQ_FRAME: begin
        if (st.active && frame_ok) begin
          if (rq.tftp_opcode == OP_DATA) begin
            st_next.reply_port = rq.udp_src_port;
            if (rq.block_number == st.expected_block) begin
              if (st.received_total > bufsz) begin
                send           = SEND_ERROR;
                status         = ST_OVERFLOW;
                st_next.active = 1'b0;
              end else begin
                send                   = SEND_ACK;
                ackb                   = rq.block_number;
                st_next.expected_block = st.expected_block + 16'd1;
                st_next.elapsed_ticks  = 17'd0;
                st_next.retry_count    = 5'd0;
                // Payload is clipped to what is left of the buffer.
                if (st.received_total < bufsz) begin
                  woff = st.received_total[31:0];
                  wlen = (room < {17'd0, dlen}) ? room[15:0] : dlen;
                end
                st_next.received_total = st.received_total + {17'd0, dlen};
                if (dlen < BLOCK_SIZE) begin
                  status         = ST_COMPLETE;
                  st_next.active = 1'b0;
                end
              end
            end
          end else if (rq.tftp_opcode == OP_ERROR) begin
            status         = ST_FAILED;
            st_next.active = 1'b0;
          end
        end
      end
      default: ;
    endcase

    rs.send_kind    = send;
    rs.ack_block    = ackb;
    rs.server_port  = st_next.reply_port;
    rs.write_offset = woff;
    rs.write_length = wlen;
    rs.status       = status;
    rs.byte_total   = (status == ST_OVERFLOW) ? bufsz : st_next.received_total;
  end
endmodule

/* hw/rtl/tftp_download_receiver.sv */
// TFTP download receiver top level: input register, decision logic, transfer
// state and result register. Depends on tdr_pkg, tdr_req_if, tdr_res_if, tdr_regs, tdr_step.
// A request is held in the input register; the transfer state is read and updated as it
// moves into the result register. Throughput: one request per cycle while no result stalls.
// Reset (rst, synchronous): transfer idle, expected block 1, totals cleared, reply port 69,
// registers at their defaults, both pipeline registers empty.

module tftp_download_receiver (
  input  logic        clk,
  input  logic        rst,
  tdr_req_if.sink     req,
  tdr_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tdr_pkg::*;

  cfg_t cfg;
  st_t  st;
  st_t  st_next;
  req_t rq;
  res_t rs_next;
  res_t rs;
  logic rq_valid;
  logic advance;

  tdr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdr_step u_step (
    .cfg     (cfg),
    .st      (st),
    .rq      (rq),
    .st_next (st_next),
    .rs      (rs_next)
  );

  // The held request moves into the result register when that register is free.
  assign advance   = rq_valid && (!res.valid || res.ready);
  assign req.ready = !rq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_valid <= 1'b0;
    end else if (req.ready) begin
      rq_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      rq.req_type     <= req.req_type;
      rq.ether_type   <= req.ether_type;
      rq.ip_protocol  <= req.ip_protocol;
      rq.udp_src_port <= req.udp_src_port;
      rq.udp_dst_port <= req.udp_dst_port;
      rq.udp_length   <= req.udp_length;
      rq.tftp_opcode  <= req.tftp_opcode;
      rq.block_number <= req.block_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.active         <= 1'b0;
      st.expected_block <= 16'd1;
      st.received_total <= 33'd0;
      st.retry_count    <= 5'd0;
      st.elapsed_ticks  <= 17'd0;
      st.reply_port     <= SERVER_PORT_DEFAULT;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rs <= rs_next;
    end
  end

  assign res.send_kind    = rs.send_kind;
  assign res.ack_block    = rs.ack_block;
  assign res.server_port  = rs.server_port;
  assign res.write_offset = rs.write_offset;
  assign res.write_length = rs.write_length;
  assign res.status       = rs.status;
  assign res.byte_total   = rs.byte_total;

  // While a result is shown, the state is the one left by that result's request.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_RUN) |-> !st.active)
    else $error("transfer still active after an ending result");

  a_store_on_ack: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.write_length != 16'd0) |-> (res.send_kind == SEND_ACK))
    else $error("payload stored without an ACK");

  a_overflow_total: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_OVERFLOW) |->
      (res.send_kind == SEND_ERROR && res.byte_total == {1'b0, cfg.buffer_size}))
    else $error("overflow stop with wrong reply or total");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> ($stable(st) && res.valid))
    else $error("transfer state changed while a result was stalled");
endmodule

/* sim/tdr_reply_checker.sv */
// Reply checker for the TFTP download receiver: watches the request, result and APB
// channels, predicts each reply and compares it with what the block sends.
// Depends on tdr_pkg, tdr_req_if and tdr_res_if.
`timescale 1ns / 100ps

module tdr_reply_checker
  import tdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tdr_req_if          req_mon,
  tdr_res_if          res_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          n_results,
  output int          n_acks,
  output int          n_errors_sent,
  output int          n_resends,
  output int          n_stops
);

  // Our own copy of the registers and of the transfer state.
  cfg_t        cfg;
  logic        live;
  logic [15:0] want_blk;
  logic [32:0] got_total;
  logic [4:0]  tries;
  logic [16:0] idle_ticks;
  logic [15:0] peer_port;

  res_t expected_replies[$];
  int   n_req_seen = 0;
  int   n_res_seen = 0;

  assign pending   = n_req_seen - n_res_seen;
  assign n_results = n_res_seen;

  function automatic res_t next_reply(input req_t r);
    res_t        o;
    logic [15:0] dlen;
    logic [32:0] room;
    o = '0;
    if (r.req_type == REQ_START) begin
      live       = 1'b1;
      want_blk   = 16'd1;
      got_total  = '0;
      tries      = '0;
      idle_ticks = '0;
      peer_port  = SERVER_PORT_DEFAULT;
    end else if (r.req_type == REQ_TICK && live) begin
      if (idle_ticks != ELAPSED_MAX) idle_ticks = idle_ticks + 17'd1;
      if (idle_ticks > {1'b0, cfg.timeout_ticks}) begin
        tries = tries + 5'd1;
        if (tries > {1'b0, cfg.max_retries}) begin
          o.status = ST_FAILED;
          live     = 1'b0;
        end else begin
          o.send_kind = SEND_RESEND;
          idle_ticks  = '0;
        end
      end
    end else if (r.req_type == REQ_FRAME && live) begin
      if (r.ether_type == ETHERTYPE_IPV4 && r.ip_protocol == UDP_PROTOCOL &&
          r.udp_dst_port == cfg.local_port && r.udp_length >= DATA_HDR_LEN) begin
        if (r.tftp_opcode == OP_DATA) begin
          peer_port = r.udp_src_port;
          if (r.block_number == want_blk) begin
            dlen = r.udp_length - DATA_HDR_LEN;
            if (got_total > {1'b0, cfg.buffer_size}) begin
              o.send_kind = SEND_ERROR;
              o.status    = ST_OVERFLOW;
              live        = 1'b0;
            end else begin
              o.send_kind = SEND_ACK;
              o.ack_block = r.block_number;
              want_blk    = want_blk + 16'd1;
              idle_ticks  = '0;
              tries       = '0;
              // Only the part of the payload that still fits is stored.
              if (got_total < {1'b0, cfg.buffer_size}) begin
                room           = {1'b0, cfg.buffer_size} - got_total;
                o.write_offset = got_total[31:0];
                o.write_length = (room < {17'd0, dlen}) ? room[15:0] : dlen;
              end
              got_total = got_total + {17'd0, dlen};
              if (dlen < BLOCK_SIZE) begin
                o.status = ST_COMPLETE;
                live     = 1'b0;
              end
            end
          end
        end else if (r.tftp_opcode == OP_ERROR) begin
          o.status = ST_FAILED;
          live     = 1'b0;
        end
      end
    end
    o.server_port = peer_port;
    o.byte_total  = (o.status == ST_OVERFLOW) ? {1'b0, cfg.buffer_size} : got_total;
    return o;
  endfunction

  always @(posedge clk) begin
    req_t got_req;
    res_t seen;
    res_t want;
    logic bad;
    if (rst) begin
      cfg.local_port    = LOCAL_PORT_RST;
      cfg.buffer_size   = BUFFER_SIZE_RST;
      cfg.timeout_ticks = TIMEOUT_RST;
      cfg.max_retries   = MAX_RETRIES_RST;
      live       = 1'b0;
      want_blk   = 16'd1;
      got_total  = '0;
      tries      = '0;
      idle_ticks = '0;
      peer_port  = SERVER_PORT_DEFAULT;
      expected_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LOCAL_PORT:  cfg.local_port    = pwdata[15:0];
          REG_BUFFER_SIZE: cfg.buffer_size   = pwdata;
          REG_TIMEOUT:     cfg.timeout_ticks = pwdata[15:0];
          REG_MAX_RETRIES: cfg.max_retries   = pwdata[3:0];
          default: ;
        endcase
      end

      // Results first: a result never belongs to a request taken at the same edge.
      if (res_mon.valid && res_mon.ready) begin
        seen.send_kind    = res_mon.send_kind;
        seen.ack_block    = res_mon.ack_block;
        seen.server_port  = res_mon.server_port;
        seen.write_offset = res_mon.write_offset;
        seen.write_length = res_mon.write_length;
        seen.status       = res_mon.status;
        seen.byte_total   = res_mon.byte_total;
        n_res_seen <= n_res_seen + 1;
        case (seen.send_kind)
          SEND_ACK:    n_acks++;
          SEND_ERROR:  n_errors_sent++;
          SEND_RESEND: n_resends++;
          default: ;
        endcase
        if (seen.status != ST_RUN) n_stops++;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tdr_reply_checker: result transfer with nothing expected: kind=%0d st=%0d",
                     seen.send_kind, seen.status);
        end else begin
          want = expected_replies.pop_front();
          bad = (seen.send_kind !== want.send_kind) || (seen.ack_block !== want.ack_block) ||
                (seen.server_port !== want.server_port) ||
                (seen.write_offset !== want.write_offset) ||
                (seen.write_length !== want.write_length) ||
                (seen.status !== want.status) || (seen.byte_total !== want.byte_total);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("tdr_reply_checker: mismatch on result %0d", n_res_seen);
              $display("  expected kind=%0d ack=%0d port=%0d off=%0d len=%0d st=%0d total=%0d",
                       want.send_kind, want.ack_block, want.server_port, want.write_offset,
                       want.write_length, want.status, want.byte_total);
              $display("  actual   kind=%0d ack=%0d port=%0d off=%0d len=%0d st=%0d total=%0d",
                       seen.send_kind, seen.ack_block, seen.server_port, seen.write_offset,
                       seen.write_length, seen.status, seen.byte_total);
            end
          end
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        got_req.req_type     = req_mon.req_type;
        got_req.ether_type   = req_mon.ether_type;
        got_req.ip_protocol  = req_mon.ip_protocol;
        got_req.udp_src_port = req_mon.udp_src_port;
        got_req.udp_dst_port = req_mon.udp_dst_port;
        got_req.udp_length   = req_mon.udp_length;
        got_req.tftp_opcode  = req_mon.tftp_opcode;
        got_req.block_number = req_mon.block_number;
        expected_replies.push_back(next_reply(got_req));
        n_req_seen <= n_req_seen + 1;
      end
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the TFTP download receiver: clock, reset, APB register writes,
// request stimulus and result back-pressure. Depends on tdr_pkg, the channel
// interfaces, tftp_download_receiver and tdr_reply_checker.
`timescale 1ns / 100ps

module tb_top;
  import tdr_pkg::*;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [15:0] OP_ACK       = 16'd4;
  localparam logic [15:0] FULL_ULEN    = DATA_HDR_LEN + BLOCK_SIZE;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          RUN_LIMIT_NS = 20_000_000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int n_results;
  int n_acks;
  int n_errors_sent;
  int n_resends;
  int n_stops;
  int n_sent = 0;

  bit          fast_mode = 1'b0;
  int          hold_asks = 0;
  int          holds_done = 0;
  logic [15:0] port_now = LOCAL_PORT_RST;

  tdr_req_if req_ch ();
  tdr_res_if res_ch ();

  tftp_download_receiver u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tdr_reply_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_mon       (req_ch),
    .res_mon       (res_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors        (errors),
    .pending       (pending),
    .n_results     (n_results),
    .n_acks        (n_acks),
    .n_errors_sent (n_errors_sent),
    .n_resends     (n_resends),
    .n_stops       (n_stops)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top: run limit reached with %0d results outstanding", pending);
    $display("tb_top: FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off when asked for.
  initial begin
    int span;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (fast_mode || $urandom_range(0, 99) < 65) begin
        res_ch.ready <= 1'b1;
        span = fast_mode ? 64 : $urandom_range(1, 24);
        repeat (span) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        repeat (span) @(posedge clk);
      end
    end
  end

  function automatic req_t ctl_item(input logic [1:0] kind);
    req_t r;
    r.req_type     = kind;
    r.ether_type   = 16'($urandom);
    r.ip_protocol  = 8'($urandom);
    r.udp_src_port = 16'($urandom);
    r.udp_dst_port = 16'($urandom);
    r.udp_length   = 16'($urandom);
    r.tftp_opcode  = 16'($urandom);
    r.block_number = 16'($urandom);
    return r;
  endfunction

  function automatic req_t data_frame(input logic [15:0] blk, input logic [15:0] ulen);
    req_t r;
    r.req_type     = REQ_FRAME;
    r.ether_type   = ETHERTYPE_IPV4;
    r.ip_protocol  = UDP_PROTOCOL;
    r.udp_src_port = 16'($urandom);
    r.udp_dst_port = port_now;
    r.udp_length   = ulen;
    r.tftp_opcode  = OP_DATA;
    r.block_number = blk;
    return r;
  endfunction

  // Mostly full blocks, so transfers run long; some short ones end them.
  function automatic logic [15:0] pick_ulen();
    int n;
    n = $urandom_range(0, 99);
    if (n < 75) return FULL_ULEN;
    if (n < 90) return DATA_HDR_LEN + 16'($urandom_range(0, 511));
    return 16'($urandom_range(525, 65535));
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    int n;
    gap = 0;
    if (!fast_mode) begin
      n = $urandom_range(0, 99);
      if (n >= 95) gap = $urandom_range(8, 25);
      else if (n >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.req_type;
    req_ch.ether_type   <= r.ether_type;
    req_ch.ip_protocol  <= r.ip_protocol;
    req_ch.udp_src_port <= r.udp_src_port;
    req_ch.udp_dst_port <= r.udp_dst_port;
    req_ch.udp_length   <= r.udp_length;
    req_ch.tftp_opcode  <= r.tftp_opcode;
    req_ch.block_number <= r.block_number;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
  endtask

  // Stops offering requests and waits until every expected result has arrived.
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] port, input logic [31:0] bsize,
                            input logic [15:0] tmo, input logic [3:0] retries);
    wait_drain();
    reg_write(REG_LOCAL_PORT, {16'd0, port});
    reg_write(REG_BUFFER_SIZE, bsize);
    reg_write(REG_TIMEOUT, {16'd0, tmo});
    reg_write(REG_MAX_RETRIES, {28'd0, retries});
    port_now = port;
  endtask

  initial begin
    req_t        item;
    int          n;
    logic [15:0] next_blk;
    bit          maybe_live;
    logic [31:0] bsize;

    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_FRAME;
    req_ch.ether_type   <= '0;
    req_ch.ip_protocol  <= '0;
    req_ch.udp_src_port <= '0;
    req_ch.udp_dst_port <= '0;
    req_ch.udp_length   <= '0;
    req_ch.tftp_opcode  <= '0;
    req_ch.block_number <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the register defaults (buffer size 0).
    send_req(data_frame(16'd1, FULL_ULEN));   // idle: ignored
    send_req(ctl_item(REQ_TICK));
    send_req(ctl_item(REQ_UNUSED));
    send_req(ctl_item(REQ_START));
    send_req(data_frame(16'd1, FULL_ULEN));   // exact fill: ACK with nothing stored
    send_req(data_frame(16'd2, FULL_ULEN));   // past the buffer: overflow stop
    send_req(ctl_item(REQ_START));
    item = data_frame(16'd1, FULL_ULEN);
    item.ether_type = 16'h86DD;
    send_req(item);
    item = data_frame(16'd1, FULL_ULEN);
    item.ip_protocol = 8'd6;
    send_req(item);
    item = data_frame(16'd1, FULL_ULEN);
    item.udp_dst_port = port_now + 16'd1;
    send_req(item);
    send_req(data_frame(16'd1, DATA_HDR_LEN - 16'd1));
    item = data_frame(16'd1, FULL_ULEN);
    item.tftp_opcode = OP_ACK;
    send_req(item);
    send_req(data_frame(16'd7, FULL_ULEN));   // wrong block only moves the reply port
    item = data_frame(16'd1, FULL_ULEN);
    item.tftp_opcode = OP_ERROR;
    send_req(item);
    send_req(ctl_item(REQ_START));
    send_req(data_frame(16'd1, DATA_HDR_LEN)); // empty block completes
    send_req(ctl_item(REQ_START));
    send_req(ctl_item(REQ_START));             // restart while active

    set_config(16'hFFFF, 32'd1000, 16'd0, 4'd0);
    send_req(ctl_item(REQ_START));
    send_req(ctl_item(REQ_TICK));              // no retries allowed: fails at once
    send_req(ctl_item(REQ_START));
    send_req(data_frame(16'd1, 16'd712));
    send_req(data_frame(16'd2, 16'hFFFF));     // clipped to the room left
    send_req(data_frame(16'd3, FULL_ULEN));

    set_config(16'hFFFF, 32'd1000, 16'd0, 4'hF);
    send_req(ctl_item(REQ_START));
    send_req(ctl_item(REQ_TICK));
    send_req(ctl_item(REQ_TICK));

    // Random part: mostly live transfers with random content, some noise.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: bsize = $urandom_range(0, 3000);
        1: bsize = 32'hFFFF_FFFF;
        2: bsize = 32'd0;
        3: bsize = $urandom_range(0, 20000);
        4: bsize = $urandom_range(0, 200000);
        5: bsize = $urandom_range(500, 3000);
        6: bsize = $urandom;
        default: bsize = $urandom_range(0, 1500);
      endcase
      set_config((p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF : 16'($urandom), bsize,
                 (p == 3) ? 16'hFFFF : 16'($urandom_range(0, 30)),
                 (p == 0) ? 4'd0 : (p == 1) ? 4'hF : 4'($urandom_range(0, 15)));
      send_req(ctl_item(REQ_START));
      next_blk   = 16'd1;
      maybe_live = 1'b1;
      for (int k = 0; k < 200; k++) begin
        if (k == 100 && (p == 2 || p == 5)) hold_asks++;
        if (k == 100 && p == 3) wait_drain();
        n = $urandom_range(0, 99);
        if (n < 4 || (!maybe_live && n < 40)) begin
          item       = ctl_item(REQ_START);
          next_blk   = 16'd1;
          maybe_live = 1'b1;
        end else if (n < 26) begin
          item = ctl_item(REQ_TICK);
        end else if (n < 72) begin
          item     = data_frame(next_blk, pick_ulen());
          next_blk = next_blk + 16'd1;
          if (item.udp_length < FULL_ULEN) maybe_live = 1'b0;
        end else if (n < 78) begin
          item = data_frame(n[0] ? next_blk - 16'd1 : 16'($urandom), pick_ulen());
        end else if (n < 81) begin
          item = data_frame(next_blk, pick_ulen());
          item.tftp_opcode = OP_ERROR;
          maybe_live = 1'b0;
        end else if (n < 83) begin
          item = ctl_item(REQ_UNUSED);
        end else begin
          item = data_frame(next_blk, pick_ulen());
          case ($urandom_range(0, 5))
            0: item.ether_type   = 16'($urandom);
            1: item.ip_protocol  = 8'($urandom);
            2: item.udp_dst_port = 16'($urandom);
            3: item.udp_length   = 16'($urandom_range(0, 11));
            4: item.tftp_opcode  = 16'($urandom);
            default: item = ctl_item(REQ_FRAME);
          endcase
        end
        send_req(item);
      end
    end

    // Full-rate burst: requests back to back while the result side stays ready.
    set_config(16'd0, 32'hFFFF_FFFF, 16'd3, 4'd2);
    fast_mode = 1'b1;
    send_req(ctl_item(REQ_START));
    for (int i = 1; i <= 30; i++) send_req(data_frame(16'(i), FULL_ULEN));
    repeat (12) send_req(ctl_item(REQ_TICK));
    fast_mode = 1'b0;

    wait_drain();
    repeat (10) @(posedge clk);
    $display("tb_top: %0d requests, %0d results: %0d ACK, %0d ERROR, %0d resend, %0d stops",
             n_sent, n_results, n_acks, n_errors_sent, n_resends, n_stops);
    $display("tb_top: covered frame filtering, clipping, exact fill, overflow, retries, %s",
             "restarts, long stalls and a full-rate burst");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
